@@ sv/positional_list_engine_macros.svh @@
// Assertion macros shared by the positional list engine RTL.
// Depends on a clk and an active-low rst_n in the scope of each use.
`ifndef POSITIONAL_LIST_ENGINE_MACROS_SVH
`define POSITIONAL_LIST_ENGINE_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define PLE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define PLE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/ple_pkg.sv @@
// Shared constants, codes and controller/datapath bundles for the list engine.
// No dependencies.
package ple_pkg;

    localparam int CAPACITY   = 256;
    localparam int ITEM_W     = 32;
    localparam int ADDR_W     = $clog2(CAPACITY);
    localparam int COUNT_W    = $clog2(CAPACITY + 1);
    localparam int OP_W       = 3;
    localparam int POS_W      = 8;
    localparam int STAT_W     = 2;
    localparam int IN_BITS    = OP_W + POS_W + ITEM_W;
    localparam int OUT_BITS   = STAT_W + ITEM_W + COUNT_W;
    localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    typedef enum logic [OP_W-1:0] {
        OP_INS_HEAD = 3'd0,
        OP_INS_TAIL = 3'd1,
        OP_INS_AT   = 3'd2,
        OP_REM_HEAD = 3'd3,
        OP_REM_TAIL = 3'd4,
        OP_REM_AT   = 3'd5,
        OP_READ_AT  = 3'd6
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE    = 2'd0,
        ST_REFUSED = 2'd1,
        ST_FULL    = 2'd2
    } stat_t;

    // Anchor position captured with a request.
    typedef enum logic [1:0] {
        BASE_ZERO,
        BASE_POS,
        BASE_LAST,
        BASE_COUNT
    } bsel_t;

    // Memory read address source.
    typedef enum logic [1:0] {
        RD_BASE,
        RD_UP,
        RD_DN
    } rsel_t;

    typedef struct packed {
        logic  load;
        bsel_t bsel;
        logic  cur_from_count;
        logic  rd_en;
        rsel_t rsel;
        logic  wr_shift;
        logic  wr_put;
        logic  cur_dec;
        logic  cur_inc;
        logic  grab;
        logic  cnt_inc;
        logic  cnt_dec;
        logic  finish;
        stat_t stat;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
        logic pos_ok;
        logic cur_gt_base;
        logic more_dn;
        logic out_free;
    } sts_t;

endpackage

@@ sv/ple_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ple_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ sv/ple_ctrl.sv @@
// Sequencer for the list engine: decodes a request and steps the datapath.
// Depends on ple_pkg.
module ple_ctrl
    import ple_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [OP_W-1:0] operation,
    input  sts_t            sts,
    output cmd_t            cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_FETCH,
        S_GRAB,
        S_UP_RD,
        S_UP_WR,
        S_DN_RD,
        S_DN_WR,
        S_DONE
    } state_t;

    typedef enum logic [0:0] {
        K_REMOVE,
        K_READ
    } kind_t;

    state_t state_reg, state_next;
    stat_t  stat_reg, stat_next;
    kind_t  kind_reg, kind_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        stat_next  = stat_reg;
        kind_next  = kind_reg;
        cmd        = '0;
        cmd.bsel   = BASE_ZERO;
        cmd.rsel   = RD_BASE;
        cmd.stat   = stat_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    stat_next  = ST_DONE;
                    state_next = S_DONE;
                    case (op_t'(operation))
                        OP_INS_HEAD:
                        begin
                            cmd.bsel = BASE_ZERO;
                            cmd.cur_from_count = 1'b1;
                            if (sts.full) stat_next = ST_FULL;
                            else state_next = S_UP_RD;
                        end
                        OP_INS_TAIL:
                        begin
                            cmd.bsel = BASE_COUNT;
                            cmd.cur_from_count = 1'b1;
                            if (sts.full) stat_next = ST_FULL;
                            else state_next = S_UP_RD;
                        end
                        OP_INS_AT:
                        begin
                            cmd.bsel = BASE_POS;
                            cmd.cur_from_count = 1'b1;
                            if (!sts.pos_ok) stat_next = ST_REFUSED;
                            else if (sts.full) stat_next = ST_FULL;
                            else state_next = S_UP_RD;
                        end
                        OP_REM_HEAD, OP_REM_TAIL:
                        begin
                            cmd.bsel  = (op_t'(operation) == OP_REM_HEAD) ? BASE_ZERO
                                                                          : BASE_LAST;
                            kind_next = K_REMOVE;
                            if (sts.empty) stat_next = ST_REFUSED;
                            else state_next = S_FETCH;
                        end
                        OP_REM_AT, OP_READ_AT:
                        begin
                            cmd.bsel  = BASE_POS;
                            kind_next = (op_t'(operation) == OP_READ_AT) ? K_READ : K_REMOVE;
                            if (!sts.pos_ok) stat_next = ST_REFUSED;
                            else state_next = S_FETCH;
                        end
                        default:
                        begin
                            stat_next = ST_REFUSED;
                        end
                    endcase
                end
            end
            S_FETCH:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rsel   = RD_BASE;
                state_next = S_GRAB;
            end
            S_GRAB:
            begin
                cmd.grab   = 1'b1;
                state_next = (kind_reg == K_READ) ? S_DONE : S_DN_RD;
            end
            S_UP_RD:
            begin
                if (sts.cur_gt_base)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rsel   = RD_UP;
                    state_next = S_UP_WR;
                end
                else
                begin
                    cmd.wr_put  = 1'b1;
                    cmd.cnt_inc = 1'b1;
                    state_next  = S_DONE;
                end
            end
            S_UP_WR:
            begin
                cmd.wr_shift = 1'b1;
                cmd.cur_dec  = 1'b1;
                state_next   = S_UP_RD;
            end
            S_DN_RD:
            begin
                if (sts.more_dn)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rsel   = RD_DN;
                    state_next = S_DN_WR;
                end
                else
                begin
                    cmd.cnt_dec = 1'b1;
                    state_next  = S_DONE;
                end
            end
            S_DN_WR:
            begin
                cmd.wr_shift = 1'b1;
                cmd.cur_inc  = 1'b1;
                state_next   = S_DN_RD;
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            stat_reg  <= ST_DONE;
            kind_reg  <= K_READ;
        end
        else
        begin
            state_reg <= state_next;
            stat_reg  <= stat_next;
            kind_reg  <= kind_next;
        end
    end

endmodule

@@ sv/ple_datapath.sv @@
// Datapath of the list engine: list memory, count, cursor and result register.
// Depends on ple_pkg, ple_ram and positional_list_engine_macros.svh.
`include "positional_list_engine_macros.svh"

module ple_datapath
    import ple_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [POS_W-1:0] position,
    input  logic [ITEM_W-1:0] item,
    input  cmd_t             cmd,
    output sts_t             sts,
    input  logic             out_ready,
    output logic             out_valid,
    output logic [STAT_W-1:0] out_status,
    output logic [ITEM_W-1:0] out_item,
    output logic [COUNT_W-1:0] out_count
);

    logic [COUNT_W-1:0] count_reg, count_next;
    logic [COUNT_W-1:0] base_reg, base_next;
    logic [COUNT_W-1:0] cur_reg;
    logic [COUNT_W-1:0] cur_p1, cur_m1;
    logic [ITEM_W-1:0]  item_reg;
    logic [ITEM_W-1:0]  result_reg;
    logic               out_valid_reg;
    logic [STAT_W-1:0]  out_status_reg;
    logic [ITEM_W-1:0]  out_item_reg;
    logic [COUNT_W-1:0] out_count_reg;

    logic              we;
    logic [ADDR_W-1:0] waddr, raddr;
    logic [ITEM_W-1:0] wdata, rdata;

    assign cur_p1 = cur_reg + COUNT_W'(1);
    assign cur_m1 = cur_reg - COUNT_W'(1);

    always_comb
    begin
        case (cmd.bsel)
            BASE_ZERO:  base_next = '0;
            BASE_POS:   base_next = COUNT_W'(position);
            BASE_LAST:  base_next = count_reg - COUNT_W'(1);
            BASE_COUNT: base_next = count_reg;
            default:    base_next = '0;
        endcase
    end

    always_comb
    begin
        case (cmd.rsel)
            RD_BASE: raddr = base_reg[ADDR_W-1:0];
            RD_UP:   raddr = cur_m1[ADDR_W-1:0];
            RD_DN:   raddr = cur_p1[ADDR_W-1:0];
            default: raddr = base_reg[ADDR_W-1:0];
        endcase
    end

    assign we    = cmd.wr_shift | cmd.wr_put;
    assign waddr = cmd.wr_put ? base_reg[ADDR_W-1:0] : cur_reg[ADDR_W-1:0];
    assign wdata = cmd.wr_put ? item_reg : rdata;

    ple_ram #(
        .WIDTH (ITEM_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (cmd.rd_en),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign sts.full        = (count_reg >= COUNT_W'(CAPACITY));
    assign sts.empty       = (count_reg == '0);
    assign sts.pos_ok      = (COUNT_W'(position) < count_reg);
    assign sts.cur_gt_base = (cur_reg > base_reg);
    assign sts.more_dn     = (cur_p1 < count_reg);
    assign sts.out_free    = !out_valid_reg || out_ready;

    always_comb
    begin
        count_next = count_reg;
        if (cmd.cnt_inc)
        begin
            count_next = count_reg + COUNT_W'(1);
        end
        else if (cmd.cnt_dec)
        begin
            count_next = count_reg - COUNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: no reset.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            base_reg   <= base_next;
            item_reg   <= item;
            result_reg <= '0;
            cur_reg    <= cmd.cur_from_count ? count_reg : base_next;
        end
        else
        begin
            if (cmd.cur_dec) cur_reg <= cur_m1;
            if (cmd.cur_inc) cur_reg <= cur_p1;
            if (cmd.grab)    result_reg <= rdata;
        end
        if (cmd.finish)
        begin
            out_status_reg <= cmd.stat;
            out_item_reg   <= result_reg;
            out_count_reg  <= count_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_item   = out_item_reg;
    assign out_count  = out_count_reg;

    `PLE_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= COUNT_W'(CAPACITY), "count beyond capacity")
    `PLE_ASSERT_NOW(a_grow_not_full, cmd.cnt_inc, !sts.full, "insert into a full list")
    `PLE_ASSERT_NOW(a_shrink_not_empty, cmd.cnt_dec, !sts.empty, "remove from an empty list")
    `PLE_ASSERT_NOW(a_shift_in_range, cmd.wr_shift, cur_reg < COUNT_W'(CAPACITY), "shift out of range")
    `PLE_ASSERT_NEXT(a_finish_shows, cmd.finish, out_valid_reg, "finished request not presented")

endmodule

@@ sv/positional_list_engine.sv @@
// A refused or full request goes straight to S_DONE, a read passes S_FETCH and S_GRAB, an
// insert at position p moves entries p..n-1 up one place from the end down and then writes the
// item, a removal fetches entry p and then moves the entries above it down one place.
// One request at a time: the next is accepted once S_DONE has staged the result, which waits
// for a free output register. Each entry moves through the one read port, then the write port.
// Reset (rst_n, asynchronous, active low) empties the list; entries are not cleared.
//
// Top level of the positional list engine: ple_ctrl sequences, ple_datapath holds
// the list memory and the output register. Depends on ple_pkg, ple_ctrl and ple_datapath.
module positional_list_engine
    import ple_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // Request stream
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // tdata from bit 0: operation[2:0], position[10:3], item[42:11], zero pad
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // Result stream
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // tdata from bit 0: status[1:0], result_item[33:2], count[42:34], zero pad
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    logic [OP_W-1:0]    operation;
    logic [POS_W-1:0]   position;
    logic [ITEM_W-1:0]  item;
    logic [STAT_W-1:0]  status;
    logic [ITEM_W-1:0]  result_item;
    logic [COUNT_W-1:0] count;

    cmd_t cmd;
    sts_t sts;

    // Unpack the request fields.
    assign operation = s_axis_tdata[OP_W-1:0];
    assign position  = s_axis_tdata[OP_W +: POS_W];
    assign item      = s_axis_tdata[OP_W + POS_W +: ITEM_W];

    // Controller: decode the request, then walk the datapath through the shift.
    ple_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .operation (operation),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Datapath: list memory, count, cursor and the output register that lets a
    // result wait while the next request is already being worked on.
    ple_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .position   (position),
        .item       (item),
        .cmd        (cmd),
        .sts        (sts),
        .out_ready  (m_axis_tready),
        .out_valid  (m_axis_tvalid),
        .out_status (status),
        .out_item   (result_item),
        .out_count  (count)
    );

    // Pack the result fields, pad to whole bytes.
    assign m_axis_tdata = {{(OUT_TDATA_W - OUT_BITS){1'b0}}, count, result_item, status};

endmodule
